>>> rtl/core/fwrk_pkg.sv
`timescale 1ns / 1ps

package fwrk_pkg;

  // defaults for the top level parameters
  localparam int DEPTH_DEF     = 32;
  localparam int KEY_WIDTH_DEF = 16;

  // fixed field widths of the transactions
  localparam int CMD_W       = 2;
  localparam int KEY_FIELD_W = 16;
  localparam int STATUS_W    = 2;
  localparam int OCC_W       = 6;

  // command codes
  localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_POP_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_PUSH_FULL = 2'd3;

  // input transaction
  typedef struct packed {
    logic [CMD_W-1:0]       cmd;
    logic [KEY_FIELD_W-1:0] key;
  } in_t;

  // result transaction
  typedef struct packed {
    logic [KEY_FIELD_W-1:0] head_key;
    logic [STATUS_W-1:0]    status;
    logic [OCC_W-1:0]       occupancy;
    logic                   is_empty;
  } out_t;

  // controller states
  typedef enum logic {
    S_IDLE,
    S_APPLY
  } state_t;

  // operation broadcast to every cell
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_COMPARE,
    OP_PUSH,
    OP_SHIFT_ALL,
    OP_SHIFT_HIT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
  } cell_ctl_t;

endpackage

>>> rtl/core/fifo_with_remove_by_key_unit.sv
`timescale 1ns / 1ps
// sequence: the accepting edge registers the key compare in every cell and enters the apply
//   state; the apply state runs the hit chain along the cells and shifts or appends, and
//   registers the result and the result strobe
// a new transaction is taken only while idle; busy is high in the apply state
// reset: synchronous, clears the count, controller state and result strobe; cell keys
//   are not cleared and are read only after being written
// the result is shown for one cycle only, the receiver cannot stall it
module fifo_with_remove_by_key_unit #(
  parameter int DEPTH     = fwrk_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH = fwrk_pkg::KEY_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  fwrk_pkg::in_t  item,
  output logic           busy,
  output logic           done,
  output fwrk_pkg::out_t result
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  fwrk_pkg::cell_ctl_t   ctl;
  logic [KEY_WIDTH-1:0]  key_bus;
  logic [CNT_W-1:0]      count;
  logic [KEY_WIDTH-1:0]  cell_key [DEPTH];
  logic [DEPTH:0]        hit;

  // controller
  fwrk_ctrl #(
    .DEPTH     (DEPTH),
    .KEY_WIDTH (KEY_WIDTH),
    .CNT_W     (CNT_W)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .item    (item),
    .head    (cell_key[0]),
    .found   (hit[DEPTH]),
    .busy    (busy),
    .ctl     (ctl),
    .key_bus (key_bus),
    .count   (count),
    .done    (done),
    .result  (result)
  );

  assign hit[0] = 1'b0;

  // row of cells, head in cell 0, each taking its right neighbor's key on a shift
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [KEY_WIDTH-1:0] right_key;
    if (g == DEPTH - 1) begin : g_last
      assign right_key = '0;
    end else begin : g_mid
      assign right_key = cell_key[g+1];
    end
    fwrk_cell #(
      .KEY_WIDTH (KEY_WIDTH),
      .CNT_W     (CNT_W),
      .INDEX     (g)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .key_in   (key_bus),
      .count    (count),
      .next_key (right_key),
      .hit_in   (hit[g]),
      .key_out  (cell_key[g]),
      .hit_out  (hit[g+1])
    );
  end

endmodule

>>> rtl/core/fwrk_cell.sv
`timescale 1ns / 1ps

module fwrk_cell #(
  parameter int KEY_WIDTH = fwrk_pkg::KEY_WIDTH_DEF,
  parameter int CNT_W     = 6,
  parameter int INDEX     = 0
) (
  input  logic                  clk,
  input  fwrk_pkg::cell_ctl_t   ctl,
  input  logic [KEY_WIDTH-1:0]  key_in,
  input  logic [CNT_W-1:0]      count,
  input  logic [KEY_WIDTH-1:0]  next_key,
  input  logic                  hit_in,
  output logic [KEY_WIDTH-1:0]  key_out,
  output logic                  hit_out
);

  localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

  logic [KEY_WIDTH-1:0] stored_key;
  logic                 match;

  // a hit here or in any cell nearer the head moves this cell
  assign hit_out = hit_in | match;
  assign key_out = stored_key;

  // local compare, append and gap closing
  always_ff @(posedge clk) begin
    case (ctl.op)
      fwrk_pkg::OP_COMPARE: begin
        match <= (stored_key == key_in) && (IDX < count);
      end
      fwrk_pkg::OP_PUSH: begin
        if (count == IDX) begin
          stored_key <= key_in;
        end
      end
      fwrk_pkg::OP_SHIFT_ALL: begin
        stored_key <= next_key;
      end
      fwrk_pkg::OP_SHIFT_HIT: begin
        if (hit_out) begin
          stored_key <= next_key;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> rtl/core/fwrk_ctrl.sv
`timescale 1ns / 1ps

module fwrk_ctrl #(
  parameter int DEPTH     = fwrk_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH = fwrk_pkg::KEY_WIDTH_DEF,
  parameter int CNT_W     = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  fwrk_pkg::in_t         item,
  input  logic [KEY_WIDTH-1:0]  head,
  input  logic                  found,
  output logic                  busy,
  output fwrk_pkg::cell_ctl_t   ctl,
  output logic [KEY_WIDTH-1:0]  key_bus,
  output logic [CNT_W-1:0]      count,
  output logic                  done,
  output fwrk_pkg::out_t        result
);

  localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

  fwrk_pkg::state_t            state;
  fwrk_pkg::state_t            state_next;
  logic [fwrk_pkg::CMD_W-1:0]  cmd_q;
  logic [KEY_WIDTH-1:0]        key_q;
  logic [CNT_W-1:0]            count_next;
  fwrk_pkg::out_t              result_next;
  logic                        accept;

  assign busy   = (state == fwrk_pkg::S_APPLY);
  assign accept = start && !busy;

  // key for the compare stage comes straight in, for the append from the register
  assign key_bus = busy ? key_q : KEY_WIDTH'(item.key);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      fwrk_pkg::S_IDLE: begin
        if (start) begin
          state_next = fwrk_pkg::S_APPLY;
        end
      end
      fwrk_pkg::S_APPLY: begin
        state_next = fwrk_pkg::S_IDLE;
      end
      default: begin
        state_next = fwrk_pkg::S_IDLE;
      end
    endcase
  end

  // cell operation, count update and result
  always_comb begin
    ctl.op      = fwrk_pkg::OP_HOLD;
    count_next  = count;
    result_next = '0;
    case (state)
      fwrk_pkg::S_IDLE: begin
        if (start) begin
          ctl.op = fwrk_pkg::OP_COMPARE;
        end
      end
      fwrk_pkg::S_APPLY: begin
        case (cmd_q)
          fwrk_pkg::CMD_PUSH: begin
            if (count < FULL) begin
              ctl.op     = fwrk_pkg::OP_PUSH;
              count_next = count + CNT_W'(1);
            end else begin
              result_next.status = fwrk_pkg::ST_PUSH_FULL;
            end
          end
          fwrk_pkg::CMD_POP: begin
            if (count != '0) begin
              ctl.op               = fwrk_pkg::OP_SHIFT_ALL;
              count_next           = count - CNT_W'(1);
              result_next.head_key = fwrk_pkg::KEY_FIELD_W'(head);
            end else begin
              result_next.status = fwrk_pkg::ST_POP_EMPTY;
            end
          end
          fwrk_pkg::CMD_REMOVE: begin
            ctl.op = fwrk_pkg::OP_SHIFT_HIT;
            if (found) begin
              count_next = count - CNT_W'(1);
            end else begin
              result_next.status = fwrk_pkg::ST_NOT_FOUND;
            end
          end
          default: begin
          end
        endcase
        result_next.occupancy = fwrk_pkg::OCC_W'(count_next);
        result_next.is_empty  = (count_next == '0);
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fwrk_pkg::S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= busy;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= item.cmd;
      key_q <= KEY_WIDTH'(item.key);
    end
    if (busy) begin
      result <= result_next;
    end
  end

endmodule

>>> rtl/core/fwrk_checker.sv
`timescale 1ns / 1ps

module fwrk_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input logic           done,
  input fwrk_pkg::out_t result
);

  // an accepted transaction occupies the block for the next cycle
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  // every busy cycle ends in exactly one result strobe
  assert property (@(posedge clk) disable iff (rst) busy |=> (done && !busy))
    else $error("busy cycle not followed by a result");

  // a result is never shown while a transaction is in work
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // only a successful pop carries a head key
  assert property (@(posedge clk) disable iff (rst)
    (done && (result.status != fwrk_pkg::ST_OK)) |-> (result.head_key == '0))
    else $error("head key on a failed transaction");

  // a pop on empty leaves the queue empty
  assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == fwrk_pkg::ST_POP_EMPTY)) |-> result.is_empty)
    else $error("pop on empty reported with entries held");

endmodule

bind fifo_with_remove_by_key_unit fwrk_checker u_fwrk_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
